// ===== sv/line_segment_window_clip_top_defines.svh =====
// assertion macros shared by the clipper modules
// needs clk_i and rst_ni in the including module
`ifndef LINE_SEGMENT_WINDOW_CLIP_TOP_DEFINES_SVH
`define LINE_SEGMENT_WINDOW_CLIP_TOP_DEFINES_SVH

// property that holds on every clock edge out of reset
`define LSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define LSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lsc_pkg.sv =====
// shared widths, types and helpers of the segment clipper
// no dependencies
package lsc_pkg;

  localparam int COORD_W    = 21;
  localparam int DELTA_W    = COORD_W + 1;
  localparam int DEN_W      = DELTA_W;
  localparam int NUM_W      = COORD_W + 3;
  localparam int CROSS_W    = NUM_W + DEN_W + 1;
  localparam int PROD_W     = DELTA_W + NUM_W;
  localparam int QUO_W      = COORD_W;
  localparam int LERP_LAT   = QUO_W + 3;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;
  localparam int FIFO_CW    = 2;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } ratio_t;

  typedef struct packed {
    ratio_t lo;
    ratio_t hi;
    logic   rej;
  } axis_t;

  typedef struct packed {
    logic [COORD_W-1:0]        x0;
    logic [COORD_W-1:0]        y0;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } base_t;

  typedef struct packed {
    logic   vis;
    base_t  base;
    ratio_t lo;
    ratio_t hi;
  } seg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  localparam ratio_t ZERO_R = '{num: NUM_W'(0), den: DEN_W'(1)};
  localparam ratio_t ONE_R  = '{num: NUM_W'(1), den: DEN_W'(1)};

  function automatic logic signed [CROSS_W-1:0] mul_nd(input logic signed [NUM_W-1:0] num,
                                                       input logic [DEN_W-1:0] den);
    logic signed [DEN_W:0] sd;
    sd = {1'b0, den};
    mul_nd = num * sd;
  endfunction

  // entry and exit candidates of one axis; entry clamped below at 0, exit clamped above at 1
  function automatic axis_t axis_eval(input logic signed [DELTA_W-1:0] d,
                                      input logic signed [NUM_W-1:0] near,
                                      input logic signed [NUM_W-1:0] far);
    axis_t a;
    logic [DEN_W-1:0] mag;
    logic signed [NUM_W-1:0] lon;
    logic signed [NUM_W-1:0] hin;
    logic signed [NUM_W-1:0] dene;
    mag  = d[DELTA_W-1] ? DEN_W'(-d) : DEN_W'(d);
    lon  = d[DELTA_W-1] ? -far : near;
    hin  = d[DELTA_W-1] ? -near : far;
    dene = {{(NUM_W-DEN_W){1'b0}}, mag};
    a.rej = (d == '0) && ((near > 0) || (far < 0));
    if (d == '0) begin
      a.lo = ZERO_R;
      a.hi = ONE_R;
    end else begin
      a.lo = (lon < 0) ? ZERO_R : ratio_t'{num: lon, den: mag};
      a.hi = (hin >= dene) ? ONE_R : ratio_t'{num: hin, den: mag};
    end
    axis_eval = a;
  endfunction

endpackage

// ===== sv/lsc_front.sv =====
// front end: accepts segments, finds entry and exit fractions and visibility
// depends on lsc_pkg and the shared assertion macros
`include "line_segment_window_clip_top_defines.svh"
module lsc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lsc_pkg::COORD_W-1:0] start_x_i,
  input  logic [lsc_pkg::COORD_W-1:0] start_y_i,
  input  logic [lsc_pkg::COORD_W-1:0] end_x_i,
  input  logic [lsc_pkg::COORD_W-1:0] end_y_i,
  input  logic [lsc_pkg::COORD_W-1:0] win_left_i,
  input  logic [lsc_pkg::COORD_W-1:0] win_top_i,
  input  logic [lsc_pkg::COORD_W-1:0] win_size_i,
  input  lsc_pkg::fifo_stat_t         stat_i,
  output logic                        busy_o,
  output logic                        push_o,
  output lsc_pkg::seg_t               seg_o
);

  localparam int PadW = lsc_pkg::NUM_W - lsc_pkg::COORD_W;

  logic stall;
  logic [5:0] v_q;

  logic signed [lsc_pkg::NUM_W-1:0] x0e, y0e, le, te, se;
  logic signed [lsc_pkg::DELTA_W-1:0] dx, dy;

  lsc_pkg::base_t b1_q, b2_q, b3_q, b4_q, b5_q;
  logic signed [lsc_pkg::NUM_W-1:0] nx_q, fx_q, ny_q, fy_q;
  lsc_pkg::axis_t ax_q, ay_q, ax3_q, ay3_q;
  logic signed [lsc_pkg::CROSS_W-1:0] pl_xy_q, pl_yx_q, ph_xy_q, ph_yx_q, pa_q, pb_q;
  lsc_pkg::ratio_t lo4_q, hi4_q, lo5_q, hi5_q;
  logic rej4_q, rej5_q;
  lsc_pkg::seg_t seg_q;

  assign stall  = v_q[5] & stat_i.full;
  assign busy_o = stall;
  assign push_o = v_q[5] & ~stat_i.full;
  assign seg_o  = seg_q;

  assign x0e = {{PadW{1'b0}}, start_x_i};
  assign y0e = {{PadW{1'b0}}, start_y_i};
  assign le  = {{PadW{1'b0}}, win_left_i};
  assign te  = {{PadW{1'b0}}, win_top_i};
  assign se  = {{PadW{1'b0}}, win_size_i};
  assign dx  = {1'b0, end_x_i} - {1'b0, start_x_i};
  assign dy  = {1'b0, end_y_i} - {1'b0, start_y_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (!stall) begin
      v_q <= {v_q[4:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      b1_q <= '{x0: start_x_i, y0: start_y_i, dx: dx, dy: dy};
      nx_q <= le - x0e;
      fx_q <= le + se - x0e;
      ny_q <= te - y0e;
      fy_q <= te + se - y0e;

      b2_q <= b1_q;
      ax_q <= lsc_pkg::axis_eval(b1_q.dx, nx_q, fx_q);
      ay_q <= lsc_pkg::axis_eval(b1_q.dy, ny_q, fy_q);

      b3_q    <= b2_q;
      ax3_q   <= ax_q;
      ay3_q   <= ay_q;
      pl_xy_q <= lsc_pkg::mul_nd(ax_q.lo.num, ay_q.lo.den);
      pl_yx_q <= lsc_pkg::mul_nd(ay_q.lo.num, ax_q.lo.den);
      ph_xy_q <= lsc_pkg::mul_nd(ay_q.hi.num, ax_q.hi.den);
      ph_yx_q <= lsc_pkg::mul_nd(ax_q.hi.num, ay_q.hi.den);

      b4_q   <= b3_q;
      lo4_q  <= (pl_xy_q < pl_yx_q) ? ay3_q.lo : ax3_q.lo;
      hi4_q  <= (ph_xy_q < ph_yx_q) ? ay3_q.hi : ax3_q.hi;
      rej4_q <= ax3_q.rej | ay3_q.rej;

      b5_q   <= b4_q;
      lo5_q  <= lo4_q;
      hi5_q  <= hi4_q;
      rej5_q <= rej4_q;
      pa_q   <= lsc_pkg::mul_nd(lo4_q.num, hi4_q.den);
      pb_q   <= lsc_pkg::mul_nd(hi4_q.num, lo4_q.den);

      seg_q <= '{vis: ~rej5_q & (pa_q < pb_q), base: b5_q, lo: lo5_q, hi: hi5_q};
    end
  end

  `LSC_ASSERT_NEXT(a_stall_holds, stall, v_q[5], "stalled word left the last stage")

endmodule

// ===== sv/lsc_fifo.sv =====
// short queue between classification and interpolation
// depends on lsc_pkg and the shared assertion macros
`include "line_segment_window_clip_top_defines.svh"
module lsc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lsc_pkg::seg_t       seg_i,
  output lsc_pkg::fifo_stat_t stat_o,
  output logic                pop_o,
  output lsc_pkg::seg_t       seg_o
);

  lsc_pkg::seg_t mem_q [lsc_pkg::FIFO_DEPTH];
  logic [lsc_pkg::FIFO_AW-1:0] wr_q, rd_q;
  logic [lsc_pkg::FIFO_CW-1:0] cnt_q;

  assign stat_o.full  = cnt_q == lsc_pkg::FIFO_CW'(lsc_pkg::FIFO_DEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign pop_o        = ~stat_o.empty;
  assign seg_o        = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_o) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + lsc_pkg::FIFO_CW'(push_i) - lsc_pkg::FIFO_CW'(pop_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= seg_i;
  end

  `LSC_ASSERT(a_no_overflow, !(push_i && stat_o.full), "word pushed into a full queue")

endmodule

// ===== sv/lsc_lerp.sv =====
// one coordinate: base plus delta times a fraction, rounded half away from zero
// pipelined restoring divider, one quotient bit per stage; depends on lsc_pkg
module lsc_lerp (
  input  logic                              clk_i,
  input  logic [lsc_pkg::COORD_W-1:0]       base_i,
  input  logic signed [lsc_pkg::DELTA_W-1:0] delta_i,
  input  lsc_pkg::ratio_t                   t_i,
  output logic [lsc_pkg::COORD_W-1:0]       coord_o
);

  localparam int QW = lsc_pkg::QUO_W;
  localparam int DW = lsc_pkg::DEN_W;

  logic signed [lsc_pkg::PROD_W-1:0] prod_q;
  logic [lsc_pkg::COORD_W-1:0] base_m_q;
  logic [DW-1:0] den_m_q;
  logic neg;
  logic [lsc_pkg::PROD_W-1:0] mag;

  logic [DW-1:0] rem_q [QW+1];
  logic [QW-1:0] bits_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic neg_q [QW+1];
  logic [lsc_pkg::COORD_W-1:0] base_q [QW+1];
  logic [lsc_pkg::COORD_W-1:0] coord_q;

  logic up;
  logic [QW:0] r;

  assign neg = prod_q[lsc_pkg::PROD_W-1];
  assign mag = neg ? lsc_pkg::PROD_W'(-prod_q) : lsc_pkg::PROD_W'(prod_q);
  assign up  = {rem_q[QW], 1'b0} >= {1'b0, den_q[QW]};
  assign r   = {1'b0, quo_q[QW]} + (QW+1)'(up);
  assign coord_o = coord_q;

  always_ff @(posedge clk_i) begin
    logic [DW:0] cat;
    logic ge;
    prod_q   <= delta_i * t_i.num;
    base_m_q <= base_i;
    den_m_q  <= t_i.den;

    rem_q[0]  <= mag[QW+DW-1:QW];
    bits_q[0] <= mag[QW-1:0];
    quo_q[0]  <= '0;
    den_q[0]  <= den_m_q;
    neg_q[0]  <= neg;
    base_q[0] <= base_m_q;

    for (int k = 0; k < QW; k++) begin
      cat = {rem_q[k], bits_q[k][QW-1]};
      ge  = cat >= {1'b0, den_q[k]};
      rem_q[k+1]  <= ge ? DW'(cat - {1'b0, den_q[k]}) : cat[DW-1:0];
      bits_q[k+1] <= bits_q[k] << 1;
      quo_q[k+1]  <= {quo_q[k][QW-2:0], ge};
      den_q[k+1]  <= den_q[k];
      neg_q[k+1]  <= neg_q[k];
      base_q[k+1] <= base_q[k];
    end

    coord_q <= neg_q[QW] ? base_q[QW] - r[lsc_pkg::COORD_W-1:0]
                         : base_q[QW] + r[lsc_pkg::COORD_W-1:0];
  end

endmodule

// ===== sv/lsc_back.sv =====
// back end: four interpolation pipes and the result strobe
// depends on lsc_pkg, lsc_lerp and the shared assertion macros
`include "line_segment_window_clip_top_defines.svh"
module lsc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pop_i,
  input  lsc_pkg::seg_t               seg_i,
  output logic                        valid_o,
  output logic                        visible_o,
  output logic [lsc_pkg::COORD_W-1:0] clip_start_x_o,
  output logic [lsc_pkg::COORD_W-1:0] clip_start_y_o,
  output logic [lsc_pkg::COORD_W-1:0] clip_end_x_o,
  output logic [lsc_pkg::COORD_W-1:0] clip_end_y_o
);

  localparam int Lat = lsc_pkg::LERP_LAT;

  logic [Lat-1:0] v_q;
  logic [Lat-1:0] vis_q;
  logic [lsc_pkg::COORD_W-1:0] sx, sy, ex, ey;

  lsc_lerp u_sx (.clk_i, .base_i(seg_i.base.x0), .delta_i(seg_i.base.dx), .t_i(seg_i.lo),
                 .coord_o(sx));
  lsc_lerp u_sy (.clk_i, .base_i(seg_i.base.y0), .delta_i(seg_i.base.dy), .t_i(seg_i.lo),
                 .coord_o(sy));
  lsc_lerp u_ex (.clk_i, .base_i(seg_i.base.x0), .delta_i(seg_i.base.dx), .t_i(seg_i.hi),
                 .coord_o(ex));
  lsc_lerp u_ey (.clk_i, .base_i(seg_i.base.y0), .delta_i(seg_i.base.dy), .t_i(seg_i.hi),
                 .coord_o(ey));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[Lat-2:0], pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    vis_q <= {vis_q[Lat-2:0], seg_i.vis};
  end

  assign valid_o        = v_q[Lat-1];
  assign visible_o      = vis_q[Lat-1];
  assign clip_start_x_o = visible_o ? sx : '0;
  assign clip_start_y_o = visible_o ? sy : '0;
  assign clip_end_x_o   = visible_o ? ex : '0;
  assign clip_end_y_o   = visible_o ? ey : '0;

  `LSC_ASSERT(a_fixed_latency, pop_i |-> ##(lsc_pkg::LERP_LAT) valid_o, "word lost in back end")

endmodule

// ===== sv/line_segment_window_clip_top.sv =====
// Liang-Barsky clipping of one segment against a square window
// holds the top level; depends on lsc_pkg, lsc_front, lsc_fifo, lsc_back
//
// usage:
//   drive the seven coordinate inputs and raise start_i; the word is taken at
//   a rising edge where start_i is high and busy_o is low
//   one result comes back per word, in order, on valid_o for exactly one cycle
//   with visible_o and the four clipped coordinates (zero when not visible)
// throughput: one segment per clock, every cycle
// path from the accepting edge to valid_o: six classification stages, one
//   queue stage, then per coordinate a multiply, a load stage, a 21-stage
//   one-bit-per-stage divider and a rounding add
// busy_o rises only if the queue between the halves fills, which the back end
//   never lets happen since it drains one word every cycle
// results cannot be held off by the receiver; nothing is buffered for it
// reset clears all valid flags and the queue; words in flight are dropped
module line_segment_window_clip_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lsc_pkg::COORD_W-1:0] start_x_i,
  input  logic [lsc_pkg::COORD_W-1:0] start_y_i,
  input  logic [lsc_pkg::COORD_W-1:0] end_x_i,
  input  logic [lsc_pkg::COORD_W-1:0] end_y_i,
  input  logic [lsc_pkg::COORD_W-1:0] win_left_i,
  input  logic [lsc_pkg::COORD_W-1:0] win_top_i,
  input  logic [lsc_pkg::COORD_W-1:0] win_size_i,
  output logic                        busy_o,
  output logic                        valid_o,
  output logic                        visible_o,
  output logic [lsc_pkg::COORD_W-1:0] clip_start_x_o,
  output logic [lsc_pkg::COORD_W-1:0] clip_start_y_o,
  output logic [lsc_pkg::COORD_W-1:0] clip_end_x_o,
  output logic [lsc_pkg::COORD_W-1:0] clip_end_y_o
);

  lsc_pkg::fifo_stat_t stat;
  lsc_pkg::seg_t       push_seg, pop_seg;
  logic                push, pop;

  lsc_front u_front (
    .clk_i, .rst_ni, .start_i,
    .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .win_left_i, .win_top_i, .win_size_i,
    .stat_i(stat), .busy_o, .push_o(push), .seg_o(push_seg)
  );

  lsc_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .seg_i(push_seg),
    .stat_o(stat), .pop_o(pop), .seg_o(pop_seg)
  );

  lsc_back u_back (
    .clk_i, .rst_ni, .pop_i(pop), .seg_i(pop_seg),
    .valid_o, .visible_o,
    .clip_start_x_o, .clip_start_y_o, .clip_end_x_o, .clip_end_y_o
  );

endmodule
